[hdl/gbc_pkg.sv]
// Shared types, S-box constants and round functions of the GOST block cipher.
`default_nettype none
package gbc_pkg;

	localparam int KEY_WORDS   = 8;
	localparam int KEY_IDX_W   = 4;
	localparam int KEY_SEL_W   = $clog2(KEY_WORDS);
	localparam int ROUND_COUNT = 32;
	localparam int FWD_ROUNDS  = 24;
	localparam int ROT_LEFT    = 11;
	localparam int SBOX_COUNT  = 8;

	localparam logic ACTION_ENCRYPT = 1'b0;
	localparam logic ACTION_DECRYPT = 1'b1;

	localparam logic [3:0] SBOX [SBOX_COUNT][16] = '{
		'{4'h4, 4'hA, 4'h9, 4'h2, 4'hD, 4'h8, 4'h0, 4'hE,
		  4'h6, 4'hB, 4'h1, 4'hC, 4'h7, 4'hF, 4'h5, 4'h3},
		'{4'hE, 4'hB, 4'h4, 4'hC, 4'h6, 4'hD, 4'hF, 4'hA,
		  4'h2, 4'h3, 4'h8, 4'h1, 4'h0, 4'h7, 4'h5, 4'h9},
		'{4'h5, 4'h8, 4'h1, 4'hD, 4'hA, 4'h3, 4'h4, 4'h2,
		  4'hE, 4'hF, 4'hC, 4'h7, 4'h6, 4'h0, 4'h9, 4'hB},
		'{4'h7, 4'hD, 4'hA, 4'h1, 4'h0, 4'h8, 4'h9, 4'hF,
		  4'hE, 4'h4, 4'h6, 4'hC, 4'hB, 4'h2, 4'h5, 4'h3},
		'{4'h6, 4'hC, 4'h7, 4'h1, 4'h5, 4'hF, 4'hD, 4'h8,
		  4'h4, 4'hA, 4'h9, 4'hE, 4'h0, 4'h3, 4'hB, 4'h2},
		'{4'h4, 4'hB, 4'hA, 4'h0, 4'h7, 4'h2, 4'h1, 4'hD,
		  4'h3, 4'h6, 4'h8, 4'h5, 4'h9, 4'hC, 4'hF, 4'hE},
		'{4'hD, 4'hB, 4'h4, 4'h1, 4'h3, 4'hF, 4'h5, 4'h9,
		  4'h0, 4'hA, 4'hE, 4'h7, 4'h6, 4'h8, 4'h2, 4'hC},
		'{4'h1, 4'hF, 4'hD, 4'h0, 4'h5, 4'h7, 4'hA, 4'h4,
		  4'h9, 4'h2, 4'h3, 4'hE, 4'h6, 4'hB, 4'h8, 4'hC}
	};

	typedef logic [31:0] gbc_word_t;
	typedef gbc_word_t gbc_key_t [KEY_WORDS];

	// One pipeline slot: valid flag, direction and the two Feistel halves.
	typedef struct packed {
		logic      valid;
		logic      action;
		gbc_word_t lo;
		gbc_word_t hi;
	} gbc_stage_t;

	// Key word used by round rnd (counted from 0) of the forward schedule.
	function automatic logic [KEY_SEL_W-1:0] key_index(input int rnd);
		logic [KEY_SEL_W-1:0] sel;
		sel = KEY_SEL_W'(rnd % KEY_WORDS);
		if (rnd < FWD_ROUNDS) begin
			return sel;
		end
		return KEY_SEL_W'(KEY_WORDS - 1) - sel;
	endfunction

	// Round function: modular add, S-box substitution, rotate left.
	function automatic gbc_word_t round_f(input gbc_word_t half, input gbc_word_t subkey);
		gbc_word_t sum;
		gbc_word_t mixed;
		sum = half + subkey;
		for (int n = 0; n < SBOX_COUNT; n++) begin
			mixed[4*n +: 4] = SBOX[n][sum[4*n +: 4]];
		end
		return (mixed << ROT_LEFT) | (mixed >> (32 - ROT_LEFT));
	endfunction

endpackage
`default_nettype wire

[hdl/gost_block_cipher_top.sv]
// Top level of the pipelined GOST 28147-89 block cipher with its key registers.
// Each of the 32 rounds has one register stage, and a result appears on block_out
// with done once its block has passed the last of them.
// Throughput: one block per cycle; busy stays low and done cannot be held off.
// Reset clears all key words to zero and empties the pipeline; blocks in flight are lost.
`default_nettype none
module gost_block_cipher_top
	import gbc_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	input  wire logic [63:0]          block_in,
	input  wire logic                 action,
	output logic                      done,
	output logic [63:0]               block_out,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [KEY_IDX_W-1:0] cfg_index,
	input  wire logic [31:0]          cfg_data
);

	gbc_key_t   key;
	gbc_stage_t pipe [ROUND_COUNT+1];

	// Every round has a stage of its own, so a new block can enter in every
	// cycle and the block never needs to refuse a start.
	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	gbc_key_regs u_keys (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.key      (key)
	);

	// Stage zero is the input transfer itself. The low 32 bits of the block
	// form the first half that the round function result is folded into.
	assign pipe[0] = '{
		valid:  start && !busy,
		action: action,
		lo:     block_in[31:0],
		hi:     block_in[63:32]
	};

	// Each round picks its subkey from two fixed key words: one for the
	// forward schedule and the mirrored one for decryption, which walks the
	// same schedule from the last round back to the first.
	for (genvar r = 0; r < ROUND_COUNT; r++) begin : g_round
		localparam logic [KEY_SEL_W-1:0] EncSel = key_index(r);
		localparam logic [KEY_SEL_W-1:0] DecSel = key_index(ROUND_COUNT - 1 - r);
		gbc_word_t subkey;

		assign subkey = (pipe[r].action == ACTION_DECRYPT) ? key[DecSel] : key[EncSel];

		gbc_round u_round (
			.clk       (clk),
			.arst_n    (arst_n),
			.subkey    (subkey),
			.stage_in  (pipe[r]),
			.stage_out (pipe[r+1])
		);
	end

	// The last round's swap is undone here: the final high half becomes the
	// low word of the result. The output comes straight from the last stage.
	assign done      = pipe[ROUND_COUNT].valid;
	assign block_out = {pipe[ROUND_COUNT].lo, pipe[ROUND_COUNT].hi};

	// A strobe always stems from a transfer that has passed through every round stage.
	a_done_has_source: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, ROUND_COUNT))
		else $error("done without a block transferred 32 cycles earlier");

	// Every transferred block leaves the pipeline after passing through all round stages.
	a_block_emerges: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> ##(ROUND_COUNT-1) done)
		else $error("transferred block did not emerge after 32 cycles");

endmodule
`default_nettype wire

[hdl/gbc_key_regs.sv]
// Key word register file written through the configuration channel.
`default_nettype none
module gbc_key_regs
	import gbc_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 wr_en,
	input  wire logic [KEY_IDX_W-1:0] wr_index,
	input  wire gbc_word_t            wr_data,
	output gbc_key_t                  key
);

	gbc_key_t key_q;

	// Writes to indices beyond the last key word are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < KEY_WORDS; i++) begin
				key_q[i] <= '0;
			end
		end else if (wr_en && (wr_index < KEY_IDX_W'(KEY_WORDS))) begin
			key_q[wr_index[KEY_SEL_W-1:0]] <= wr_data;
		end
	end

	assign key = key_q;

endmodule
`default_nettype wire

[hdl/gbc_round.sv]
// One registered Feistel round of the cipher pipeline.
`default_nettype none
module gbc_round
	import gbc_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire gbc_word_t  subkey,
	input  wire gbc_stage_t stage_in,
	output gbc_stage_t      stage_out
);

	logic      valid_s1;
	logic      action_s1;
	gbc_word_t lo_s1;
	gbc_word_t hi_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= stage_in.valid;
		end
	end

	// The halves swap on the way through: the new low half is the old high half.
	always_ff @(posedge clk) begin
		if (stage_in.valid) begin
			action_s1 <= stage_in.action;
			lo_s1     <= stage_in.hi;
			hi_s1     <= stage_in.lo ^ round_f(stage_in.hi, subkey);
		end
	end

	assign stage_out = '{valid: valid_s1, action: action_s1, lo: lo_s1, hi: hi_s1};

endmodule
`default_nettype wire
